>>> rtl/cscv_pkg.sv
// cscv_pkg: shared types, sizing constants and the sequencer control store
// for the clock second-chance victim unit. No dependencies.
`default_nettype none

package cscv_pkg;

  localparam int POOL_ENTRIES   = 64;
  localparam int POOL_COUNT     = 2;
  localparam int FIX_COUNT_BITS = 8;

  localparam int TOTAL_ENTRIES = POOL_ENTRIES * POOL_COUNT;
  localparam int ENTRY_BITS    = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
  localparam int POOL_BITS     = (POOL_COUNT > 1) ? $clog2(POOL_COUNT) : 1;
  localparam int ADDR_BITS     = (TOTAL_ENTRIES > 1) ? $clog2(TOTAL_ENTRIES) : 1;
  localparam int FIXED_BITS    = $clog2(POOL_ENTRIES + 1);

  typedef enum logic [1:0] {
    MODE_ALLOC = 2'd0,
    MODE_FIX   = 2'd1,
    MODE_UNFIX = 2'd2,
    MODE_DIRTY = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STATUS_OK          = 2'd0,
    STATUS_NO_UNFIXED  = 2'd1,
    STATUS_UNSUPPORTED = 2'd2
  } status_t;

  typedef struct packed {
    mode_t      mode;
    logic       pool_select;
    logic [5:0] entry_index;
  } in_item_t;

  typedef struct packed {
    logic [5:0] victim_index;
    logic       flush_needed;
    status_t    status;
  } res_item_t;

  // one stored buffer entry
  typedef struct packed {
    logic [FIX_COUNT_BITS-1:0] fix_count;
    logic                      refer;
    logic                      dirty;
  } ent_t;

  localparam int ENT_BITS = $bits(ent_t);

  typedef logic [2:0] step_t;

  localparam step_t STEP_IDLE   = 3'd0;
  localparam step_t STEP_READ   = 3'd1;
  localparam step_t STEP_BRANCH = 3'd2;
  localparam step_t STEP_UPDATE = 3'd3;
  localparam step_t STEP_CHECK  = 3'd4;
  localparam step_t STEP_NEXT   = 3'd5;
  localparam step_t STEP_EMIT   = 3'd6;

  typedef enum logic [2:0] {
    COND_ALWAYS   = 3'd0,
    COND_NO_INPUT = 3'd1,
    COND_REJECT   = 3'd2,
    COND_ALLOC    = 3'd3,
    COND_FOUND    = 3'd4,
    COND_OUT_BUSY = 3'd5
  } cond_t;

  // control word: datapath strobes, jump condition and jump target
  typedef struct packed {
    logic  accept;
    logic  rd;
    logic  stat;
    logic  upd;
    logic  sweep;
    logic  emit;
    logic  done;
    cond_t cond;
    step_t target;
  } ucw_t;

  // when the condition holds go to target, else done returns to idle,
  // else fall through to the next step
  function automatic ucw_t ucode(step_t s);
    ucw_t w;
    w = '{accept: 1'b0, rd: 1'b0, stat: 1'b0, upd: 1'b0, sweep: 1'b0,
          emit: 1'b0, done: 1'b0, cond: COND_ALWAYS, target: STEP_IDLE};
    unique case (s)
      STEP_IDLE: begin
        w.accept = 1'b1;
        w.cond   = COND_NO_INPUT;
        w.target = STEP_IDLE;
      end
      STEP_READ: begin
        w.rd     = 1'b1;
        w.stat   = 1'b1;
        w.cond   = COND_REJECT;
        w.target = STEP_EMIT;
      end
      STEP_BRANCH: begin
        w.cond   = COND_ALLOC;
        w.target = STEP_CHECK;
      end
      STEP_UPDATE: begin
        w.upd    = 1'b1;
        w.cond   = COND_ALWAYS;
        w.target = STEP_EMIT;
      end
      STEP_CHECK: begin
        w.sweep  = 1'b1;
        w.cond   = COND_FOUND;
        w.target = STEP_EMIT;
      end
      STEP_NEXT: begin
        w.rd     = 1'b1;
        w.cond   = COND_ALWAYS;
        w.target = STEP_CHECK;
      end
      STEP_EMIT: begin
        w.emit   = 1'b1;
        w.done   = 1'b1;
        w.cond   = COND_OUT_BUSY;
        w.target = STEP_EMIT;
      end
      default: begin
        w.cond   = COND_ALWAYS;
        w.target = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

>>> rtl/cscv_ram.sv
// cscv_ram: generic single-port-write, single-port-read memory with a
// registered read. Self-contained, no package needed.
`default_nettype none

module cscv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic                                  re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/clock_second_chance_victim_unit.sv
// clock_second_chance_victim_unit: microcoded clock victim selector.
// Depends on cscv_pkg (types, control store) and cscv_ram (entry table).
//
// One transaction is worked at a time; in_stall is low only while the
// sequencer idles. Fix, unfix and mark-dirty pass from acceptance to the
// result register through read, branch, write back and emit. A rejected
// allocate (bulk flush set, pool out of range, every entry fixed) goes from
// read straight to emit. In a successful allocate the hand visits 1 to
// 2*POOL_ENTRIES entries, and each visit is one read and one check of the
// single entry table. After the result register loads, the sequencer
// returns to idle before it takes the next transaction. The all-fixed test
// uses a per-pool count of fixed entries, so no scan precedes the sweep.
// Reset takes effect at once: per-entry valid bits make untouched entries
// read as zero, and there is no clearing pass.
`default_nettype none

module clock_second_chance_victim_unit (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire cscv_pkg::in_item_t   in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output cscv_pkg::res_item_t       out_data,
  input  wire logic                 cfg_write,
  input  wire logic                 cfg_data
);

  localparam int ENTRY_BITS = cscv_pkg::ENTRY_BITS;
  localparam int ADDR_BITS  = cscv_pkg::ADDR_BITS;
  localparam int POOL_BITS  = cscv_pkg::POOL_BITS;
  localparam int FIXED_BITS = cscv_pkg::FIXED_BITS;
  localparam int FIXB       = cscv_pkg::FIX_COUNT_BITS;

  cscv_pkg::step_t     step;
  cscv_pkg::step_t     step_next;
  cscv_pkg::ucw_t      ucw;
  cscv_pkg::in_item_t  item;
  cscv_pkg::res_item_t res;
  logic                bulk_flush;

  logic [ENTRY_BITS-1:0]         hand      [cscv_pkg::POOL_COUNT];
  logic [FIXED_BITS-1:0]         fixed_cnt [cscv_pkg::POOL_COUNT];
  logic [cscv_pkg::TOTAL_ENTRIES-1:0] entry_vld;
  logic                          rd_vld;

  logic [POOL_BITS-1:0]          pool_idx;
  logic [ENTRY_BITS-1:0]         cur_hand;
  logic [ENTRY_BITS-1:0]         hand_adv;
  logic [ADDR_BITS-1:0]          cur_addr;
  logic                          is_alloc;
  logic                          pool_oor;
  logic                          entry_oor;
  logic                          all_fixed;
  logic                          reject;
  cscv_pkg::status_t             status_pre;
  logic                          accept;
  logic                          out_busy;
  logic                          found;
  logic                          cond_hit;

  logic [cscv_pkg::ENT_BITS-1:0] ram_rdata;
  cscv_pkg::ent_t                ent_eff;
  cscv_pkg::ent_t                ent_wr;
  logic                          ram_we;

  assign ucw      = cscv_pkg::ucode(step);
  assign in_stall = (step != cscv_pkg::STEP_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_busy = out_valid && out_stall;

  assign is_alloc  = (item.mode == cscv_pkg::MODE_ALLOC);
  assign pool_idx  = POOL_BITS'(item.pool_select);
  assign pool_oor  = 32'(item.pool_select) >= cscv_pkg::POOL_COUNT;
  assign entry_oor = 32'(item.entry_index) >= cscv_pkg::POOL_ENTRIES;
  assign cur_hand  = hand[pool_idx];
  assign all_fixed = (fixed_cnt[pool_idx] == FIXED_BITS'(cscv_pkg::POOL_ENTRIES));
  assign hand_adv  = (32'(cur_hand) == cscv_pkg::POOL_ENTRIES - 1) ?
                     '0 : cur_hand + ENTRY_BITS'(1);

  // allocate walks the hand, the other modes address the given entry
  assign cur_addr = ADDR_BITS'(pool_idx) * ADDR_BITS'(cscv_pkg::POOL_ENTRIES) +
                    (is_alloc ? ADDR_BITS'(cur_hand) : ADDR_BITS'(item.entry_index));

  always_comb begin
    reject     = 1'b0;
    status_pre = cscv_pkg::STATUS_OK;
    if (is_alloc) begin
      priority if (bulk_flush || pool_oor) begin
        reject     = 1'b1;
        status_pre = cscv_pkg::STATUS_UNSUPPORTED;
      end else if (all_fixed) begin
        reject     = 1'b1;
        status_pre = cscv_pkg::STATUS_NO_UNFIXED;
      end else begin
        reject     = 1'b0;
      end
    end else begin
      reject = pool_oor || entry_oor;
    end
  end

  // entries never written since reset read as all zero
  assign ent_eff = rd_vld ? cscv_pkg::ent_t'(ram_rdata) : '0;
  assign found   = (ent_eff.fix_count == '0) && !ent_eff.refer;

  always_comb begin
    ram_we = 1'b0;
    ent_wr = ent_eff;
    if (ucw.upd) begin
      ram_we = 1'b1;
      unique case (item.mode)
        cscv_pkg::MODE_FIX: begin
          if (ent_eff.fix_count != '1) begin
            ent_wr.fix_count = ent_eff.fix_count + FIXB'(1);
          end
          ent_wr.refer = 1'b1;
        end
        cscv_pkg::MODE_UNFIX: begin
          if (ent_eff.fix_count != '0) begin
            ent_wr.fix_count = ent_eff.fix_count - FIXB'(1);
          end
        end
        cscv_pkg::MODE_DIRTY: begin
          ent_wr.dirty = 1'b1;
        end
        cscv_pkg::MODE_ALLOC: begin
          ram_we = 1'b0;
        end
      endcase
    end else if (ucw.sweep && (ent_eff.fix_count == '0)) begin
      // second chance: drop the reference, or clear the victim outright
      ram_we = 1'b1;
      if (ent_eff.refer) begin
        ent_wr.refer = 1'b0;
      end else begin
        ent_wr = '0;
      end
    end
  end

  always_comb begin
    unique case (ucw.cond)
      cscv_pkg::COND_ALWAYS:   cond_hit = 1'b1;
      cscv_pkg::COND_NO_INPUT: cond_hit = !in_valid;
      cscv_pkg::COND_REJECT:   cond_hit = reject;
      cscv_pkg::COND_ALLOC:    cond_hit = is_alloc;
      cscv_pkg::COND_FOUND:    cond_hit = found;
      cscv_pkg::COND_OUT_BUSY: cond_hit = out_busy;
      default:                 cond_hit = 1'b1;
    endcase
    priority if (cond_hit) begin
      step_next = ucw.target;
    end else if (ucw.done) begin
      step_next = cscv_pkg::STEP_IDLE;
    end else begin
      step_next = step + 3'd1;
    end
  end

  cscv_ram #(
    .WIDTH (cscv_pkg::ENT_BITS),
    .DEPTH (cscv_pkg::TOTAL_ENTRIES)
  ) u_ent_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cur_addr),
    .wdata (ent_wr),
    .re    (ucw.rd),
    .raddr (cur_addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      step       <= cscv_pkg::STEP_IDLE;
      bulk_flush <= 1'b0;
      entry_vld  <= '0;
      rd_vld     <= 1'b0;
      out_valid  <= 1'b0;
      for (int p = 0; p < cscv_pkg::POOL_COUNT; p++) begin
        hand[p]      <= '0;
        fixed_cnt[p] <= '0;
      end
    end else begin
      step <= step_next;
      if (cfg_write) begin
        bulk_flush <= cfg_data;
      end
      if (ucw.accept && accept) begin
        item <= in_data;
      end
      if (ucw.rd) begin
        rd_vld <= entry_vld[cur_addr];
      end
      if (ram_we) begin
        entry_vld[cur_addr] <= 1'b1;
      end
      if (ucw.stat) begin
        res <= '{victim_index: 6'd0, flush_needed: 1'b0, status: status_pre};
      end
      // the pool's count of fixed entries follows zero crossings
      if (ucw.upd && (item.mode == cscv_pkg::MODE_FIX) && (ent_eff.fix_count == '0)) begin
        fixed_cnt[pool_idx] <= fixed_cnt[pool_idx] + FIXED_BITS'(1);
      end
      if (ucw.upd && (item.mode == cscv_pkg::MODE_UNFIX) &&
          (ent_eff.fix_count == FIXB'(1))) begin
        fixed_cnt[pool_idx] <= fixed_cnt[pool_idx] - FIXED_BITS'(1);
      end
      if (ucw.sweep) begin
        hand[pool_idx] <= hand_adv;
        if (found) begin
          res <= '{victim_index: 6'(cur_hand), flush_needed: ent_eff.dirty,
                   status: cscv_pkg::STATUS_OK};
        end
      end
      if (ucw.emit && !out_busy) begin
        out_valid <= 1'b1;
        out_data  <= res;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef ASSERT_OFF
  // the sweep only runs on a pool that has an unfixed entry
  a_sweep_has_free: assert property (@(posedge clk) disable iff (rst)
    (step == cscv_pkg::STEP_CHECK) |-> !all_fixed)
    else $error("sweep running on a fully fixed pool");

  a_hand_range: assert property (@(posedge clk) disable iff (rst)
    (step == cscv_pkg::STEP_CHECK) |-> (32'(cur_hand) < cscv_pkg::POOL_ENTRIES))
    else $error("clock hand out of range");

  a_fail_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_data.status != cscv_pkg::STATUS_OK)) |->
    ((out_data.victim_index == 6'd0) && !out_data.flush_needed))
    else $error("failed allocate carries a victim");

  a_out_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(step == cscv_pkg::STEP_EMIT))
    else $error("result loaded outside the emit step");

  a_accept_reads: assert property (@(posedge clk) disable iff (rst)
    accept |=> (step == cscv_pkg::STEP_READ))
    else $error("accepted transaction did not start its table read");
`endif

endmodule

`default_nettype wire

>>> test/cscv_victim_check.sv
// cscv_victim_check: watches the request and result channels of the clock
// victim unit, predicts every result and compares. Depends on cscv_pkg.
module cscv_victim_check
  import cscv_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_stall,
  input  res_item_t out_data,
  input  logic      cfg_write,
  input  logic      cfg_data,
  output int        mismatch_count,
  output int        results_waiting
);

  logic [FIX_COUNT_BITS-1:0] fix_cnt [TOTAL_ENTRIES];
  bit                        referenced [TOTAL_ENTRIES];
  bit                        dirty [TOTAL_ENTRIES];
  logic [ENTRY_BITS-1:0]     hand [POOL_COUNT];
  bit                        bulk_flush;

  res_item_t expected_results[$];
  res_item_t oldest;

  task automatic report_mismatch(string what, int got, int want);
    $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  // updates the stored pool state for one request and returns its answer
  function automatic res_item_t apply_request(in_item_t it);
    res_item_t r;
    int base, slot, h, free_cnt, victim;
    bit found;
    r = '0;
    if (it.mode == MODE_ALLOC) begin
      if (bulk_flush || int'(it.pool_select) >= POOL_COUNT) begin
        r.status = STATUS_UNSUPPORTED;
        return r;
      end
      base = int'(it.pool_select) * POOL_ENTRIES;
      free_cnt = 0;
      for (int i = 0; i < POOL_ENTRIES; i++)
        if (fix_cnt[base + i] == 0) free_cnt++;
      r.status = STATUS_NO_UNFIXED;
      if (free_cnt == 0) return r;
      h = int'(hand[it.pool_select]) % POOL_ENTRIES;
      found = 0;
      victim = 0;
      // second chance: referenced entries lose their bit and are passed over
      for (int i = 0; i < 2 * POOL_ENTRIES && !found; i++) begin
        slot = base + h;
        if (fix_cnt[slot] == 0) begin
          if (referenced[slot]) begin
            referenced[slot] = 0;
          end else begin
            victim = h;
            found = 1;
          end
        end
        h = (h + 1) % POOL_ENTRIES;
      end
      hand[it.pool_select] = ENTRY_BITS'(h);
      if (!found) return r;
      slot = base + victim;
      r.victim_index = 6'(victim);
      r.flush_needed = dirty[slot];
      r.status = STATUS_OK;
      fix_cnt[slot] = '0;
      referenced[slot] = 0;
      dirty[slot] = 0;
      return r;
    end
    if (int'(it.pool_select) >= POOL_COUNT || int'(it.entry_index) >= POOL_ENTRIES)
      return r;
    slot = int'(it.pool_select) * POOL_ENTRIES + int'(it.entry_index);
    case (it.mode)
      MODE_FIX: begin
        if (fix_cnt[slot] != '1) fix_cnt[slot]++;
        referenced[slot] = 1;
      end
      MODE_UNFIX: begin
        if (fix_cnt[slot] != '0) fix_cnt[slot]--;
      end
      default: begin
        dirty[slot] = 1;
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TOTAL_ENTRIES; i++) begin
        fix_cnt[i] = '0;
        referenced[i] = 0;
        dirty[i] = 0;
      end
      for (int i = 0; i < POOL_COUNT; i++) hand[i] = '0;
      bulk_flush = 0;
      expected_results.delete();
      results_waiting <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with no transaction pending", int'(out_data), 0);
        end else begin
          oldest = expected_results.pop_front();
          if (out_data.victim_index !== oldest.victim_index)
            report_mismatch("victim_index", out_data.victim_index, oldest.victim_index);
          if (out_data.flush_needed !== oldest.flush_needed)
            report_mismatch("flush_needed", out_data.flush_needed, oldest.flush_needed);
          if (out_data.status !== oldest.status)
            report_mismatch("status", out_data.status, oldest.status);
        end
      end
      if (cfg_write) bulk_flush = cfg_data;
      if (in_valid && !in_stall) expected_results.push_back(apply_request(in_data));
      results_waiting <= expected_results.size();
    end
  end

endmodule

>>> test/clock_second_chance_victim_unit_tb.sv
// clock_second_chance_victim_unit_tb: drives requests, stalls and the bulk
// flush register of the clock victim unit. Depends on cscv_pkg, cscv_victim_check.
module clock_second_chance_victim_unit_tb;
  import cscv_pkg::*;

  localparam int REQUEST_TARGET = 1150;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  res_item_t out_data;
  logic      cfg_write = 1'b0;
  logic      cfg_data = 1'b0;

  int mismatches;
  int waiting;
  int requests_sent = 0;
  bit no_idle = 0;
  bit long_hold = 0;

  always #2 clk = ~clk;

  clock_second_chance_victim_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data)
  );

  cscv_victim_check victim_check (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data        (out_data),
    .cfg_write       (cfg_write),
    .cfg_data        (cfg_data),
    .mismatch_count  (mismatches),
    .results_waiting (waiting)
  );

  function automatic in_item_t req(mode_t m, int p, int e);
    in_item_t it;
    it.mode = m;
    it.pool_select = p[0];
    it.entry_index = e[5:0];
    return it;
  endfunction

  function automatic in_item_t any_request();
    return req(mode_t'($urandom_range(0, 3)), $urandom_range(0, 1), $urandom_range(0, 63));
  endfunction

  task automatic offer(in_item_t it);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_data <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    requests_sent++;
  endtask

  task automatic drain_results(int tail);
    in_valid <= 1'b0;
    do @(posedge clk); while (waiting != 0);
    repeat (tail) @(posedge clk);
  endtask

  task automatic set_bulk_flush(bit v);
    drain_results(4);
    cfg_write <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // result side: random stall before each transaction, one long hold on request
  initial begin
    int n;
    forever begin
      if (long_hold) begin
        n = 300;
        long_hold = 0;
      end else begin
        n = no_idle ? 0 : $urandom_range(0, 11);
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    #6000000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    int e, p, n, kind, round;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    set_bulk_flush(1'b0);

    // empty pools, floor of unfix, dirty victim, referenced and fixed skips
    offer(req(MODE_ALLOC, 0, 0));
    offer(req(MODE_ALLOC, 1, 63));
    offer(req(MODE_FIX, 0, 63));
    offer(req(MODE_FIX, 0, 63));
    offer(req(MODE_UNFIX, 0, 63));
    offer(req(MODE_UNFIX, 0, 63));
    offer(req(MODE_UNFIX, 0, 63));
    offer(req(MODE_DIRTY, 0, 1));
    offer(req(MODE_ALLOC, 0, 0));
    offer(req(MODE_FIX, 0, 2));
    offer(req(MODE_UNFIX, 0, 2));
    offer(req(MODE_DIRTY, 0, 2));
    offer(req(MODE_FIX, 0, 3));
    offer(req(MODE_ALLOC, 0, 63));
    offer(req(MODE_ALLOC, 0, 0));
    offer(req(MODE_DIRTY, 1, 63));
    offer(req(MODE_FIX, 1, 0));
    offer(req(MODE_ALLOC, 1, 0));

    // bulk flush set: allocations refused, other modes still act
    set_bulk_flush(1'b1);
    offer(req(MODE_ALLOC, 0, 0));
    offer(req(MODE_ALLOC, 1, 63));
    offer(req(MODE_FIX, 1, 0));
    offer(req(MODE_DIRTY, 0, 5));
    set_bulk_flush(1'b0);

    // every entry of the train pool fixed, then one freed after a full sweep
    for (int k = 0; k < POOL_ENTRIES; k++) begin
      offer(req(MODE_FIX, 1, k));
      if ($urandom_range(0, 3) == 0) offer(req(MODE_DIRTY, 1, k));
    end
    offer(req(MODE_ALLOC, 1, 0));
    offer(req(MODE_ALLOC, 1, 63));
    e = $urandom_range(1, 63);
    offer(req(MODE_UNFIX, 1, e));
    offer(req(MODE_ALLOC, 1, 0));
    for (int k = 0; k < POOL_ENTRIES; k++)
      if (k != e) offer(req(MODE_UNFIX, 1, k));
    drain_results(4);

    // fix count saturation, back to back with no idling
    no_idle = 1;
    e = $urandom_range(0, 63);
    repeat (256) offer(req(MODE_FIX, 0, e));
    repeat (254) offer(req(MODE_UNFIX, 0, e));
    repeat (66) offer(req(MODE_ALLOC, 0, $urandom_range(0, 63)));
    offer(req(MODE_UNFIX, 0, e));
    repeat (3) offer(req(MODE_ALLOC, 0, $urandom_range(0, 63)));
    no_idle = 0;
    drain_results(4);

    // result side held off while requests keep coming
    long_hold = 1;
    repeat (12) offer(any_request());

    round = 0;
    while (requests_sent < REQUEST_TARGET) begin
      round++;
      if (round == 40) begin
        set_bulk_flush(1'b1);
        repeat (20) offer(any_request());
        set_bulk_flush(1'b0);
      end
      no_idle = (round >= 80 && round < 100);
      kind = $urandom_range(0, 9);
      p = $urandom_range(0, 1);
      if (kind <= 3) begin
        offer(any_request());
      end else if (kind <= 6) begin
        // reference a few entries, some left fixed, then allocate
        n = $urandom_range(1, 6);
        repeat (n) begin
          e = $urandom_range(0, 63);
          offer(req(MODE_FIX, p, e));
          if ($urandom_range(0, 1) == 1) offer(req(MODE_UNFIX, p, e));
          if ($urandom_range(0, 9) < 3) offer(req(MODE_DIRTY, p, e));
        end
        offer(req(MODE_ALLOC, p, $urandom_range(0, 63)));
      end else begin
        n = $urandom_range(1, 4);
        repeat (n) offer(req(MODE_ALLOC, p, $urandom_range(0, 63)));
      end
    end
    no_idle = 0;

    drain_results(300);
    if (waiting != 0) $display("%0d results never arrived", waiting);
    if (mismatches == 0 && waiting == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
